// ===== hw/rtl/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Default table depth
    localparam int DEFAULT_CAPACITY = 64;

    // Request modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // Request beat
    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic capture;  // latch compare flags against the key
        logic insert;   // open a slot at the insert point
        logic remove;   // close the slot of the first match
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slt_cell.sv =====
`default_nettype none

// One slot of the sorted table. Holds one entry and the result of comparing
// it with the current key; shifts toward a neighbor on insert or remove.
module slt_cell (
    input  wire                                   clk,
    input  wire slt_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [slt_pkg::VALUE_W-1:0] key,
    input  wire                                   occ,
    input  wire logic signed [slt_pkg::VALUE_W-1:0] prev_entry,
    input  wire                                   prev_lt,
    input  wire logic signed [slt_pkg::VALUE_W-1:0] next_entry,
    output logic signed [slt_pkg::VALUE_W-1:0]    entry,
    output logic                                  lt,
    output logic                                  eq
);

    logic signed [slt_pkg::VALUE_W-1:0] entry_reg;
    logic signed [slt_pkg::VALUE_W-1:0] entry_next;
    logic                               lt_reg;
    logic                               eq_reg;

    // Shift selection: insert pulls from the lower neighbor (or takes the key
    // at the boundary), remove pulls from the upper neighbor at and past the match
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (!lt_reg)
            begin
                entry_next = prev_lt ? key : prev_entry;
            end
        end
        else if (ctrl.remove)
        begin
            if (occ && !lt_reg)
            begin
                entry_next = next_entry;
            end
        end
    end

    // Entry and compare flags (data only, no reset)
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            lt_reg <= occ && (entry_reg < key);
            eq_reg <= occ && (entry_reg == key);
        end
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_list_table_core.sv =====
`default_nettype none

// Sorted table of signed 32-bit values, ascending, duplicates allowed, held in
// a row of CAPACITY cells. A request is taken when start is high and busy is
// low; busy then stays high through the reduce and apply states, and the
// result appears on result with done high for exactly one cycle; done is
// registered from the apply state. A new request may be taken while done
// is high but not while busy. The three steps are: every cell compares its
// entry with the value, the match flags are ORed per group of 32 cells into
// registers, then the cells shift in one step and the status is formed.
// There is no flow control on the result side: done must be sampled when it
// is high. Insert on a full table reports full, remove or search on an empty
// table reports empty, a missing value reports not found; entry_count is the
// number of entries held after the request, truncated to 7 bits. Mode 3 does
// nothing and reports done.
module sorted_list_table_core #(
    parameter int CAPACITY = slt_pkg::DEFAULT_CAPACITY
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire slt_pkg::req_t  request,
    output logic                done,
    output slt_pkg::rsp_t       result
);

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int GRP_SIZE   = 32;
    localparam int NUM_GROUPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [1:0]                         mode_reg;
    logic signed [slt_pkg::VALUE_W-1:0] key_reg;
    logic signed [slt_pkg::VALUE_W-1:0] key;
    logic                               done_reg;
    slt_pkg::rsp_t                      result_reg;
    logic [1:0]                         status_next;
    logic                               accept;
    logic                               found;
    slt_pkg::cell_ctrl_t                ctrl;

    logic signed [slt_pkg::VALUE_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]                lt_w;
    logic [CAPACITY-1:0]                eq_w;
    logic [CAPACITY-1:0]                occ;
    logic [NUM_GROUPS*GRP_SIZE-1:0]     eq_pad;
    logic [NUM_GROUPS-1:0]              grp_reg;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign key    = (state_reg == S_IDLE) ? request.value : key_reg;
    assign found  = |grp_reg;

    // Cell commands
    always_comb
    begin
        ctrl.capture = accept;
        ctrl.insert  = (state_reg == S_APPLY) && (mode_reg == slt_pkg::MODE_INSERT)
                       && (count_reg != CNT_W'(CAPACITY));
        ctrl.remove  = (state_reg == S_APPLY) && (mode_reg == slt_pkg::MODE_REMOVE)
                       && found;
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [slt_pkg::VALUE_W-1:0] prev_e;
            logic signed [slt_pkg::VALUE_W-1:0] next_e;
            logic                               prev_l;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign prev_e = key;
                assign prev_l = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = entry_w[gi-1];
                assign prev_l = lt_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_e = entry_w[gi];
            end
            else
            begin : g_inner
                assign next_e = entry_w[gi+1];
            end

            slt_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .key        (key),
                .occ        (occ[gi]),
                .prev_entry (prev_e),
                .prev_lt    (prev_l),
                .next_entry (next_e),
                .entry      (entry_w[gi]),
                .lt         (lt_w[gi]),
                .eq         (eq_w[gi])
            );
        end
    endgenerate

    // Match flags padded to whole groups
    always_comb
    begin
        eq_pad                 = '0;
        eq_pad[CAPACITY-1:0]   = eq_w;
    end

    // Registered group OR of match flags
    generate
        for (gi = 0; gi < NUM_GROUPS; gi++)
        begin : g_grp
            always_ff @(posedge clk)
            begin
                if (state_reg == S_REDUCE)
                begin
                    grp_reg[gi] <= |eq_pad[gi*GRP_SIZE +: GRP_SIZE];
                end
            end
        end
    endgenerate

    // Status and next count
    always_comb
    begin
        status_next = slt_pkg::STATUS_DONE;
        count_next  = count_reg;
        unique case (mode_reg)
            slt_pkg::MODE_INSERT:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = slt_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            slt_pkg::MODE_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status_next = slt_pkg::STATUS_EMPTY;
                end
                else if (!found)
                begin
                    status_next = slt_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            slt_pkg::MODE_SEARCH:
            begin
                if (count_reg == '0)
                begin
                    status_next = slt_pkg::STATUS_EMPTY;
                end
                else if (!found)
                begin
                    status_next = slt_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = slt_pkg::STATUS_DONE;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = accept ? S_REDUCE : S_IDLE;
            S_REDUCE: state_next = S_APPLY;
            S_APPLY:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_APPLY);
            if (state_reg == S_APPLY)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= request.mode;
            key_reg  <= request.value;
        end
        if (state_reg == S_APPLY)
        begin
            result_reg.status      <= status_next;
            result_reg.entry_count <= slt_pkg::COUNT_W'(count_next);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // Count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A result beat leaves the block ready for the next request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A successful insert grows the table by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    // A successful remove shrinks the table by one and reports done
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove |=> (count_reg == $past(count_reg) - CNT_W'(1))
                        && (result.status == slt_pkg::STATUS_DONE))
        else $error("remove did not shrink count");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sorted_list_table_core_test.sv =====
`default_nettype none

module sorted_list_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1880;
    localparam int SEGMENT_LEN  = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // Unused mode: no table change, reports done
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    // Segment flavors of the random traffic
    localparam int SEG_FILL  = 0;
    localparam int SEG_DRAIN = 1;
    localparam int SEG_MIXED = 2;

    typedef struct packed {
        req_t req;
        rsp_t rsp;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    // Requests waiting to be driven, and outcomes waiting for their result beat
    req_t     pending_requests[$];
    outcome_t awaited_outcomes[$];

    // Predicted table contents, ascending
    logic signed [VALUE_W-1:0] held_values[$];

    // Values the stimulus believes are held, used to aim removes and searches
    logic signed [VALUE_W-1:0] planned_values[$];

    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};
    int unsigned peak_count = 0;

    sorted_list_table_core #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predicted table, return the expected result
    function automatic rsp_t apply_request(req_t req);
        rsp_t                      rsp;
        logic signed [VALUE_W-1:0] key;
        int                        pos;
        int                        hit;
        key = $signed(req.value);
        rsp.status = STATUS_DONE;
        case (req.mode)
            MODE_INSERT:
            begin
                if (held_values.size() >= CAPACITY)
                    rsp.status = STATUS_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] < key)
                        pos++;
                    held_values.insert(pos, key);
                end
            end
            MODE_REMOVE, MODE_SEARCH:
            begin
                if (held_values.size() == 0)
                    rsp.status = STATUS_EMPTY;
                else
                begin
                    hit = -1;
                    for (int i = 0; i < held_values.size(); i++)
                        if (hit < 0 && held_values[i] == key)
                            hit = i;
                    if (hit < 0)
                        rsp.status = STATUS_NOT_FOUND;
                    else if (req.mode == MODE_REMOVE)
                        held_values.delete(hit);
                end
            end
            default: ;
        endcase
        rsp.entry_count = COUNT_W'(held_values.size());
        return rsp;
    endfunction

    // Value mix: small range for duplicates, edge values, full random
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return VALUE_W'(int'($urandom_range(12)) - 6);
        if (roll < 55)
        begin
            case ($urandom_range(6))
                0: return VALUE_MIN;
                1: return VALUE_MIN + 1;
                2: return -1;
                3: return 0;
                4: return 1;
                5: return VALUE_MAX - 1;
                default: return VALUE_MAX;
            endcase
        end
        return $urandom;
    endfunction

    // Pick a value that is probably held, or any value
    function automatic logic signed [VALUE_W-1:0] aim_value(int unsigned hit_pct, bit take);
        int unsigned               idx;
        logic signed [VALUE_W-1:0] v;
        if (planned_values.size() != 0 && $urandom_range(99) < hit_pct)
        begin
            idx = $urandom_range(planned_values.size() - 1);
            v = planned_values[idx];
            if (take)
                planned_values.delete(idx);
            return v;
        end
        return pick_value();
    endfunction

    task automatic queue_request(logic [1:0] mode, logic signed [VALUE_W-1:0] value);
        req_t r;
        r.mode = mode;
        r.value = value;
        pending_requests.push_back(r);
    endtask

    // Request driver: holds a beat until taken, random idle cycles between beats
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic taken;
        logic next_start;
        req_t next_req;
        logic may_idle;
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                awaited_outcomes.push_back('{req: request, rsp: apply_request(request)});
                accepted_count++;
            end
            next_start = start && !taken;
            next_req = request;
            // no idling over a stretch in the middle of the run
            may_idle = !(accepted_count >= 700 && accepted_count < 1000);
            if (!next_start && pending_requests.size() != 0
                && !(may_idle && $urandom_range(99) < 10))
            begin
                next_req = pending_requests.pop_front();
                next_start = 1'b1;
            end
            start   <= next_start;
            request <= next_req;
        end
    end

    // Result monitor: every done beat is checked against the oldest outcome
    always @(posedge clk)
    begin : watch
        outcome_t exp;
        if (rst_n && done)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing outstanding: status %0d count %0d",
                             $realtime, result.status, result.entry_count);
            end
            else
            begin
                exp = awaited_outcomes.pop_front();
                checked_count++;
                status_seen[result.status]++;
                if (result.entry_count > peak_count)
                    peak_count = result.entry_count;
                if (result.status !== exp.rsp.status
                    || result.entry_count !== exp.rsp.entry_count)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t: mode %0d value %0d: expected status %0d count %0d,",
                                  " got status %0d count %0d"},
                                 $realtime, exp.req.mode, $signed(exp.req.value),
                                 exp.rsp.status, exp.rsp.entry_count,
                                 result.status, result.entry_count);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_outcomes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int unsigned roll;
        int          seg_kind;
        int unsigned ins_lim;
        int unsigned rem_lim;
        int unsigned srch_lim;
        logic signed [VALUE_W-1:0] v;

        // Directed: empty table, extremes, duplicates, absent values, unused mode
        queue_request(MODE_SEARCH, 0);
        queue_request(MODE_REMOVE, 5);
        queue_request(MODE_NOP, 0);
        queue_request(MODE_INSERT, VALUE_MAX);
        queue_request(MODE_INSERT, VALUE_MIN);
        queue_request(MODE_INSERT, 0);
        queue_request(MODE_INSERT, 0);
        queue_request(MODE_INSERT, -1);
        queue_request(MODE_SEARCH, VALUE_MIN);
        queue_request(MODE_SEARCH, VALUE_MAX);
        queue_request(MODE_SEARCH, 1);
        queue_request(MODE_REMOVE, 0);
        queue_request(MODE_SEARCH, 0);
        queue_request(MODE_REMOVE, 0);
        queue_request(MODE_SEARCH, 0);
        queue_request(MODE_REMOVE, 12345);
        queue_request(MODE_NOP, -1);
        queue_request(MODE_REMOVE, VALUE_MAX);
        queue_request(MODE_REMOVE, VALUE_MIN);
        queue_request(MODE_REMOVE, -1);
        queue_request(MODE_SEARCH, -1);
        queue_request(MODE_REMOVE, -1);

        // Random: alternating fill, drain and mixed segments
        seg_kind = SEG_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % SEGMENT_LEN == 0)
                seg_kind = (n / SEGMENT_LEN) % 3;
            case (seg_kind)
                SEG_FILL:  begin ins_lim = 80; rem_lim = 88; srch_lim = 98; end
                SEG_DRAIN: begin ins_lim = 10; rem_lim = 85; srch_lim = 98; end
                default:   begin ins_lim = 35; rem_lim = 65; srch_lim = 98; end
            endcase
            roll = $urandom_range(99);
            if (roll < ins_lim)
            begin
                v = pick_value();
                if (planned_values.size() < CAPACITY)
                    planned_values.push_back(v);
                queue_request(MODE_INSERT, v);
            end
            else if (roll < rem_lim)
                queue_request(MODE_REMOVE, aim_value(85, 1'b1));
            else if (roll < srch_lim)
                queue_request(MODE_SEARCH, aim_value(70, 1'b0));
            else
                queue_request(MODE_NOP, $urandom);
        end

        // Reset, then let the driver run
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start)
            @(posedge clk);
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests checked, %0d errors; table peaked at %0d of %0d entries",
                 checked_count, error_count, peak_count, CAPACITY);
        $display("status seen: done %0d, full %0d, empty %0d, not found %0d",
                 status_seen[STATUS_DONE], status_seen[STATUS_FULL],
                 status_seen[STATUS_EMPTY], status_seen[STATUS_NOT_FOUND]);
        if (error_count == 0 && awaited_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
